FILE: hdl/mlpt_pkg.sv
// ----------------------------------------------------------------------------
// mlpt_pkg
// Shared constants, codes and types of the multi-level page table unit.
// ----------------------------------------------------------------------------
package mlpt_pkg;

  localparam int MAX_LEVELS     = 4;
  localparam int MAX_LEVEL_BITS = 8;
  localparam int NODE_POOL      = 64;
  localparam int ADDR_BITS      = 32;
  localparam int FRAME_BITS     = 24;

  localparam int NODE_W     = $clog2(NODE_POOL);
  localparam int STORE_AW   = NODE_W + MAX_LEVEL_BITS;
  localparam int STORE_DEPTH = NODE_POOL * (2 ** MAX_LEVEL_BITS);
  localparam int ENTRY_W    = FRAME_BITS + 1;
  localparam int USED_W     = $clog2(NODE_POOL + 1);
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
  localparam int SUM_W      = $clog2(ADDR_BITS + 1);
  localparam int OFF_W      = $clog2(ADDR_BITS);

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [2:0] CFG_LEVEL_COUNT = 3'd0;
  localparam logic [2:0] CFG_LEVEL_BITS0 = 3'd1;
  localparam logic [2:0] CFG_LEVEL_BITS1 = 3'd2;
  localparam logic [2:0] CFG_LEVEL_BITS2 = 3'd3;
  localparam logic [2:0] CFG_LEVEL_BITS3 = 3'd4;

  localparam logic [2:0] LEVEL_COUNT_RST = 3'd2;
  localparam logic [3:0] LEVEL_BITS_RST  = 4'd8;

endpackage

FILE: hdl/mlpt_ram.sv
// ----------------------------------------------------------------------------
// mlpt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/multi_level_page_table_unit.sv
// ----------------------------------------------------------------------------
// multi_level_page_table_unit
// Page table walker with insert over one node store RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* takes one request beat: tuser is the request kind (0 lookup,
//    1 insert), tdata carries the virtual address and the frame to map.
//  - out_* gives one result beat per request: tuser is the status (hit or
//    inserted, lookup miss, node pool exhausted), tdata the frame, the
//    physical address and the four per-level index fields.
//  - cfg_* writes the level count and per-level index widths; always ready.
//    Write only while no request is in flight.
// Throughput: one request at a time. For each level read, a lookup passes
// S_ISSUE (RAM address) and then S_EVAL (registered data); S_FINISH then
// loads the result. An insert reads the directory levels alike, adds an
// S_ALLOC write per new node and writes the leaf in S_LEAF. The next
// request is taken in the cycle after the result loads; the node store
// RAM's single read port sets this.
// Reset: the store is cleared by a sweep over all 16384 entries (one entry per
// cycle); in_tready stays low during the sweep, cfg writes are still taken.
// Stall: the result sits in an output register; the walker finishes the next
// request and then holds until that register is free.
// ----------------------------------------------------------------------------
module multi_level_page_table_unit
  import mlpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // request: tuser = {req_type}; tdata = {map_frame[55:32], vaddr[31:0]}
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,
  input  logic [0:0]   in_tuser,
  // result: tuser = {status}; tdata = {index_level_3[87:80],
  //   index_level_2[79:72], index_level_1[71:64], index_level_0[63:56],
  //   phys_addr[55:24], frame_out[23:0]}
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,
  output logic [1:0]   out_tuser,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ISSUE, S_EVAL, S_ALLOC, S_LEAF, S_FINISH
  } state_t;

  // config registers
  logic [2:0] level_count_r;
  logic [3:0] lbits_r [MAX_LEVELS];

  // control
  state_t              state_r, state_nxt;
  logic [STORE_AW-1:0] clr_r, clr_nxt;
  logic [USED_W-1:0]   nodes_used_r, nodes_used_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;

  // request context
  logic                      req_r, req_nxt;
  logic [ADDR_BITS-1:0]      va_r, va_nxt;
  logic [FRAME_BITS-1:0]     frame_r, frame_nxt;
  logic [MAX_LEVEL_BITS-1:0] idx_r [MAX_LEVELS];
  logic [MAX_LEVEL_BITS-1:0] idx_nxt [MAX_LEVELS];
  logic [OFF_W-1:0]          off_r, off_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [LVL_W-1:0]          lvl_r, lvl_nxt;
  logic [NODE_W-1:0]         node_r, node_nxt;
  status_t                   status_r, status_nxt;
  logic                      alloc_r, alloc_nxt;

  logic [87:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]  out_tuser_r, out_tuser_nxt;

  // RAM ports
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [STORE_AW-1:0] slot_addr;
  logic [ENTRY_W-1:0]  ram_rdata;

  // address split of the incoming request
  logic [MAX_LEVEL_BITS-1:0] idx_c [MAX_LEVELS];
  logic [OFF_W-1:0]          off_c;
  logic [CNT_W-1:0]          n_c;

  logic                  in_fire;
  logic                  out_free;
  logic [LVL_W-1:0]      lvl_inc;
  logic [CNT_W-1:0]      missing;
  logic [ADDR_BITS-1:0]  phys;
  logic [ADDR_BITS-1:0]  off_mask;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign lvl_inc  = lvl_r + 1'b1;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---- split: clamp level count and widths, cut fields from the top
  always_comb begin
    logic [CNT_W-1:0]          n;
    logic [SUM_W-1:0]          used;
    logic [3:0]                b;
    logic [SUM_W-1:0]          sh;
    logic [ADDR_BITS-1:0]      shifted;
    logic [MAX_LEVEL_BITS-1:0] m;
    n = CNT_W'(level_count_r);
    if (level_count_r == 3'd0) begin
      n = CNT_W'(1);
    end else if (level_count_r > 3'(MAX_LEVELS)) begin
      n = CNT_W'(MAX_LEVELS);
    end
    used    = '0;
    sh      = '0;
    shifted = '0;
    m       = '0;
    off_c   = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      b = lbits_r[i];
      if (b == 4'd0) b = 4'd1;
      if (b > 4'(MAX_LEVEL_BITS)) b = 4'(MAX_LEVEL_BITS);
      idx_c[i] = '0;
      if (CNT_W'(i) < n) begin
        used     = used + SUM_W'(b);
        sh       = SUM_W'(ADDR_BITS) - used;
        shifted  = in_tdata[ADDR_BITS-1:0] >> sh;
        m        = MAX_LEVEL_BITS'({MAX_LEVEL_BITS{1'b1}} >> (4'(MAX_LEVEL_BITS) - b));
        idx_c[i] = shifted[MAX_LEVEL_BITS-1:0] & m;
        off_c    = OFF_W'(sh);
      end
    end
    n_c = n;
  end

  // ---- node store
  assign slot_addr = {node_r, idx_r[lvl_r]};
  assign missing   = (n_r - CNT_W'(1)) - CNT_W'(lvl_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_addr;
    ram_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      S_ALLOC: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, FRAME_BITS'(nodes_used_r)};
      end
      S_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, frame_r};
      end
      default: ;
    endcase
  end

  mlpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_addr),
    .rdata (ram_rdata)
  );

  // ---- physical address: offset bits pass through, frame above them
  assign off_mask = ~({ADDR_BITS{1'b1}} << off_r);
  assign phys     = (ADDR_BITS'(frame_r) << off_r) + (va_r & off_mask);

  // ---- walker
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    nodes_used_nxt = nodes_used_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    req_nxt        = req_r;
    va_nxt         = va_r;
    frame_nxt      = frame_r;
    idx_nxt        = idx_r;
    off_nxt        = off_r;
    n_nxt          = n_r;
    lvl_nxt        = lvl_r;
    node_nxt       = node_r;
    status_nxt     = status_r;
    alloc_nxt      = alloc_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_nxt    = in_tuser[0];
          va_nxt     = in_tdata[ADDR_BITS-1:0];
          frame_nxt  = in_tdata[ADDR_BITS +: FRAME_BITS];
          idx_nxt    = idx_c;
          off_nxt    = off_c;
          n_nxt      = n_c;
          lvl_nxt    = '0;
          node_nxt   = '0;
          alloc_nxt  = 1'b0;
          status_nxt = ST_OK;
          // single level insert goes straight to the leaf write
          state_nxt  = (in_tuser[0] && n_c == CNT_W'(1)) ? S_LEAF : S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (CNT_W'(lvl_r) == n_r - CNT_W'(1)) begin
          // leaf read, lookup only
          if (ram_rdata[FRAME_BITS]) begin
            frame_nxt = ram_rdata[FRAME_BITS-1:0];
          end else begin
            status_nxt = ST_MISS;
          end
          state_nxt = S_FINISH;
        end else if (ram_rdata[FRAME_BITS]) begin
          node_nxt  = ram_rdata[NODE_W-1:0];
          lvl_nxt   = lvl_inc;
          state_nxt = (req_r && CNT_W'(lvl_inc) == n_r - CNT_W'(1)) ? S_LEAF : S_ISSUE;
        end else if (!req_r) begin
          status_nxt = ST_MISS;
          state_nxt  = S_FINISH;
        end else if (alloc_r) begin
          state_nxt = S_ALLOC;
        end else if ((USED_W + 1)'(nodes_used_r) + (USED_W + 1)'(missing) >
                     (USED_W + 1)'(NODE_POOL)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_FINISH;
        end else begin
          alloc_nxt = 1'b1;
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        // entry written this cycle points at the freshly taken node
        node_nxt       = nodes_used_r[NODE_W-1:0];
        nodes_used_nxt = nodes_used_r + 1'b1;
        lvl_nxt        = lvl_inc;
        state_nxt      = (CNT_W'(lvl_inc) == n_r - CNT_W'(1)) ? S_LEAF : S_ISSUE;
      end
      S_LEAF: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = status_r;
          out_tdata_nxt  = {idx_r[3], idx_r[2], idx_r[1], idx_r[0],
                            (status_r == ST_OK) ? phys : '0,
                            (status_r == ST_OK) ? frame_r : '0};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      nodes_used_r  <= USED_W'(1);
      out_tvalid_r  <= 1'b0;
      level_count_r <= LEVEL_COUNT_RST;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        lbits_r[i] <= LEVEL_BITS_RST;
      end
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      nodes_used_r <= nodes_used_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LEVEL_COUNT: level_count_r <= cfg_data[2:0];
          CFG_LEVEL_BITS0: lbits_r[0]    <= cfg_data;
          CFG_LEVEL_BITS1: lbits_r[1]    <= cfg_data;
          CFG_LEVEL_BITS2: lbits_r[2]    <= cfg_data;
          CFG_LEVEL_BITS3: lbits_r[3]    <= cfg_data;
          default: ;
        endcase
      end
    end
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    req_r       <= req_nxt;
    va_r        <= va_nxt;
    frame_r     <= frame_nxt;
    idx_r       <= idx_nxt;
    off_r       <= off_nxt;
    n_r         <= n_nxt;
    lvl_r       <= lvl_nxt;
    node_r      <= node_nxt;
    status_r    <= status_nxt;
    alloc_r     <= alloc_nxt;
  end

  // ---- checks
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= USED_W'(NODE_POOL))
    else $error("node pool count past its limit");

  a_alloc_bumps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |=> nodes_used_r == $past(nodes_used_r) + 1'b1)
    else $error("node allocation did not advance the pool count");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r != ST_OK |-> out_tdata_r[55:0] == '0)
    else $error("failed request carries a frame or address");

  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken before the store sweep");

endmodule
